FILE: hdl/blrw_pkg.sv
package blrw_pkg;

  // Fixed field widths.
  localparam int TIME_W   = 32;
  localparam int PCT_W    = 7;
  localparam int QUO_BITS = 7;
  localparam int IDX_W    = 3;
  localparam int ADDR_W   = 4;
  localparam int DATA_W   = 32;

  // Scale factor for the fill percentage.
  localparam logic [PCT_W-1:0] PCT_SCALE = 7'd100;

  // Configuration register indexes (byte address / 4).
  localparam logic [1:0] REG_REFRESH = 2'd0;
  localparam logic [1:0] REG_GRACE   = 2'd1;
  localparam logic [1:0] REG_LOWPCT  = 2'd2;
  localparam logic [1:0] REG_HOLD    = 2'd3;

  // Reset values of the configuration registers.
  localparam logic [TIME_W-1:0] RST_REFRESH = 32'd1000;
  localparam logic [TIME_W-1:0] RST_GRACE   = 32'd10000;
  localparam logic [PCT_W-1:0]  RST_LOWPCT  = 7'd5;
  localparam logic [TIME_W-1:0] RST_HOLD    = 32'd5000;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ELAPSED,
    ST_PERIOD,
    ST_DIV,
    ST_GRACE_SUB,
    ST_GRACE_CMP,
    ST_LOW_CMP,
    ST_HOLD_SUB,
    ST_HOLD_CMP,
    ST_DONE
  } state_t;

endpackage

FILE: hdl/buffer_level_reconnect_watchdog.sv
// A poll without a station goes straight to the done state; one whose check is not due
// stops after the elapsed and period steps. A checked poll also runs the percent division,
// the grace and low compares and, when the low timer runs, the hold steps. No new poll is
// taken until the result enters the output register. One shared subtract/compare unit does
// every time difference, compare and step of the 7-step restoring percent division.
// Reset (synchronous, active high) restores the configuration defaults, clears the
// last check time and the low timer, and empties the output register.
module buffer_level_reconnect_watchdog import blrw_pkg::*; #(
  parameter int COUNT_BITS = 20
) (
  input  logic                  clk,
  input  logic                  rst,
  // Poll channel.
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [TIME_W-1:0]     now_ms,
  input  logic                  station_set,
  input  logic [COUNT_BITS-1:0] fill_count,
  input  logic [COUNT_BITS-1:0] free_count,
  input  logic                  paused,
  input  logic                  wifi_ok,
  input  logic [TIME_W-1:0]     connect_request_ms,
  input  logic                  reconnect_pending,
  // Result channel.
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  checked,
  output logic [COUNT_BITS:0]   total_count,
  output logic [PCT_W-1:0]      fill_percent,
  output logic                  set_reconnect,
  // Configuration port.
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ADDR_W-1:0]     paddr,
  input  logic [DATA_W-1:0]     pwdata,
  output logic [DATA_W-1:0]     prdata,
  output logic                  pready
);

  // Shared unit width: covers 32-bit times and the shifted divisor, plus a borrow bit.
  localparam int UW = (COUNT_BITS + 8 > TIME_W + 1) ? COUNT_BITS + 8 : TIME_W + 1;
  localparam int PW = COUNT_BITS + PCT_W;

  // Configuration registers.
  logic [TIME_W-1:0] refresh_period_ms;
  logic [TIME_W-1:0] startup_grace_ms;
  logic [PCT_W-1:0]  low_fill_percent;
  logic [TIME_W-1:0] low_hold_ms;

  // Persistent state.
  logic [TIME_W-1:0] last_check_ms;
  logic [TIME_W-1:0] low_since_ms;

  // Sequencer and working registers.
  state_t                state;
  state_t                state_next;
  logic [TIME_W-1:0]     now_r;
  logic [COUNT_BITS-1:0] fill_r;
  logic [COUNT_BITS-1:0] free_r;
  logic                  paused_r;
  logic                  wifi_r;
  logic [TIME_W-1:0]     conn_r;
  logic                  pend_r;
  logic [TIME_W-1:0]     tmp;
  logic [UW-1:0]         rem;
  logic [COUNT_BITS:0]   total_r;
  logic [QUO_BITS-1:0]   quo;
  logic [IDX_W-1:0]      bit_idx;
  logic                  grace_ok;
  logic                  res_checked;
  logic                  res_set;

  // Shared unit.
  logic [UW-1:0]         unit_a;
  logic [UW-1:0]         unit_b;
  logic [UW-1:0]         unit_diff;
  logic                  unit_lt;

  logic                  cfg_wr;
  logic                  in_take;
  logic                  out_load;
  logic [PCT_W-1:0]      pct_val;
  logic [PW-1:0]         fill_x100;
  logic                  low_cond;

  assign cfg_wr    = psel && penable && pwrite && pready;
  assign in_take   = in_valid && !in_stall;
  assign out_load  = (state == ST_DONE) && (!out_valid || !out_stall);
  assign pct_val   = (total_r == '0) ? '0 : quo;
  assign fill_x100 = PW'(fill_r) * PW'(PCT_SCALE);
  assign pready    = 1'b1;

  // Operand selection for the shared subtract/compare unit.
  always_comb begin
    unit_a = '0;
    unit_b = '0;
    case (state)
      ST_ELAPSED: begin
        unit_a = UW'(now_r);
        unit_b = UW'(last_check_ms);
      end
      ST_PERIOD: begin
        unit_a = UW'(refresh_period_ms);
        unit_b = UW'(tmp);
      end
      ST_DIV: begin
        unit_a = rem;
        unit_b = UW'(total_r) << bit_idx;
      end
      ST_GRACE_SUB: begin
        unit_a = UW'(now_r);
        unit_b = UW'(conn_r);
      end
      ST_GRACE_CMP: begin
        unit_a = UW'(tmp);
        unit_b = UW'(startup_grace_ms);
      end
      ST_LOW_CMP: begin
        unit_a = UW'(low_fill_percent);
        unit_b = UW'(pct_val);
      end
      ST_HOLD_SUB: begin
        unit_a = UW'(now_r);
        unit_b = UW'(low_since_ms);
      end
      ST_HOLD_CMP: begin
        unit_a = UW'(tmp);
        unit_b = UW'(low_hold_ms);
      end
      default: begin
        unit_a = '0;
        unit_b = '0;
      end
    endcase
  end

  assign unit_diff = unit_a - unit_b;
  assign unit_lt   = unit_diff[UW-1];

  // Low when percent <= threshold, unpaused, wifi up and grace passed or unset.
  assign low_cond = !paused_r && wifi_r && grace_ok && !unit_lt;

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = station_set ? ST_ELAPSED : ST_DONE;
        end
      end
      ST_ELAPSED:   state_next = ST_PERIOD;
      ST_PERIOD:    state_next = unit_lt ? ST_DIV : ST_DONE;
      ST_DIV:       state_next = (bit_idx == '0) ? ST_GRACE_SUB : ST_DIV;
      ST_GRACE_SUB: state_next = ST_GRACE_CMP;
      ST_GRACE_CMP: state_next = ST_LOW_CMP;
      ST_LOW_CMP:   state_next = low_cond ? ST_HOLD_SUB : ST_DONE;
      ST_HOLD_SUB:  state_next = ST_HOLD_CMP;
      ST_HOLD_CMP:  state_next = ST_DONE;
      ST_DONE: begin
        if (!out_valid || !out_stall) begin
          state_next = ST_IDLE;
        end
      end
      default:      state_next = ST_IDLE;
    endcase
  end

  // Handshake outputs of the sequencer.
  always_comb begin
    in_stall = (state != ST_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      refresh_period_ms <= RST_REFRESH;
      startup_grace_ms  <= RST_GRACE;
      low_fill_percent  <= RST_LOWPCT;
      low_hold_ms       <= RST_HOLD;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_REFRESH: refresh_period_ms <= pwdata;
        REG_GRACE:   startup_grace_ms  <= pwdata;
        REG_LOWPCT:  low_fill_percent  <= pwdata[PCT_W-1:0];
        REG_HOLD:    low_hold_ms       <= pwdata;
        default:     ;
      endcase
    end
  end

  // Register read back.
  always_comb begin
    case (paddr[3:2])
      REG_REFRESH: prdata = refresh_period_ms;
      REG_GRACE:   prdata = startup_grace_ms;
      REG_LOWPCT:  prdata = DATA_W'(low_fill_percent);
      REG_HOLD:    prdata = low_hold_ms;
      default:     prdata = '0;
    endcase
  end

  // Persistent timers.
  always_ff @(posedge clk) begin
    if (rst) begin
      last_check_ms <= '0;
      low_since_ms  <= '0;
    end else begin
      if (in_take && !station_set) begin
        low_since_ms <= '0;
      end
      if (state == ST_PERIOD && unit_lt) begin
        last_check_ms <= now_r;
      end
      if (state == ST_LOW_CMP) begin
        if (low_cond) begin
          if (low_since_ms == '0) begin
            low_since_ms <= now_r;
          end
        end else begin
          low_since_ms <= '0;
        end
      end
    end
  end

  // Working registers of the sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_checked <= 1'b0;
      res_set     <= 1'b0;
      total_r     <= '0;
      quo         <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            now_r       <= now_ms;
            fill_r      <= fill_count;
            free_r      <= free_count;
            paused_r    <= paused;
            wifi_r      <= wifi_ok;
            conn_r      <= connect_request_ms;
            pend_r      <= reconnect_pending;
            res_checked <= 1'b0;
            res_set     <= 1'b0;
            total_r     <= '0;
            quo         <= '0;
          end
        end
        ST_ELAPSED: tmp <= unit_diff[TIME_W-1:0];
        ST_PERIOD: begin
          if (unit_lt) begin
            res_checked <= 1'b1;
            rem         <= UW'(fill_x100);
            total_r     <= {1'b0, fill_r} + {1'b0, free_r};
            quo         <= '0;
            bit_idx     <= IDX_W'(QUO_BITS - 1);
          end
        end
        ST_DIV: begin
          // One restoring division step per cycle, most significant quotient bit first.
          if (!unit_lt) begin
            rem          <= unit_diff;
            quo[bit_idx] <= 1'b1;
          end
          bit_idx <= bit_idx - 1'b1;
        end
        ST_GRACE_SUB: tmp <= unit_diff[TIME_W-1:0];
        ST_GRACE_CMP: grace_ok <= (conn_r == '0) || !unit_lt;
        ST_HOLD_SUB:  tmp <= unit_diff[TIME_W-1:0];
        ST_HOLD_CMP:  res_set <= !pend_r && !unit_lt;
        default: ;
      endcase
    end
  end

  // Output register: holds a finished result while the next poll is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      checked       <= res_checked;
      total_count   <= total_r;
      fill_percent  <= pct_val;
      set_reconnect <= res_set;
    end
  end

endmodule
